[sv/rsnc_pkg.sv]
// Shared constants, register indexes and widths for the revolution-synchronous noise canceller.
package rsnc_pkg;

   // Sensor axes: three accelerometer axes followed by three gyro axes
   localparam int RSNC_AXES     = 6;
   localparam int RSNC_ACC_AXES = 3;
   localparam int RSNC_AX_W     = 3;

   // Default number of phase bins per revolution
   localparam int RSNC_BINS = 64;

   // Sample, phase and fixed-point state widths
   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 24;
   localparam int STATE_W  = 32;
   localparam int FRAC_W   = 16;

   // Configuration port widths
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register widths
   localparam int SYNC_RATE_W  = 16;
   localparam int ACC_SMOOTH_W = 16;
   localparam int DEAD_ZONE_W  = 15;

   // Register reset values
   localparam logic [SYNC_RATE_W-1:0]  SYNC_RATE_RST  = 16'd655;
   localparam logic [PHASE_W-1:0]      PHASE_STEP_RST = 24'd335544;
   localparam logic [ACC_SMOOTH_W-1:0] ACC_SMOOTH_RST = 16'd32768;
   localparam logic [DEAD_ZONE_W-1:0]  DEAD_ZONE_RST  = 15'd16;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_RATE      = 2'd0,
      CSR_PHASE_STEP     = 2'd1,
      CSR_ACC_SMOOTHING  = 2'd2,
      CSR_GYRO_DEAD_ZONE = 2'd3
   } csr_index_type;

endpackage

[sv/rsnc_if.sv]
// Valid/ready channel interfaces for sample input, result output and register writes.
interface rsnc_req_if import rsnc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       new_revolution;
   logic signed [SAMPLE_W-1:0] acc_x_in;
   logic signed [SAMPLE_W-1:0] acc_y_in;
   logic signed [SAMPLE_W-1:0] acc_z_in;
   logic signed [SAMPLE_W-1:0] gyro_x_in;
   logic signed [SAMPLE_W-1:0] gyro_y_in;
   logic signed [SAMPLE_W-1:0] gyro_z_in;

   modport source (
      output valid, new_revolution, acc_x_in, acc_y_in, acc_z_in,
             gyro_x_in, gyro_y_in, gyro_z_in,
      input  ready
   );
   modport sink (
      input  valid, new_revolution, acc_x_in, acc_y_in, acc_z_in,
             gyro_x_in, gyro_y_in, gyro_z_in,
      output ready
   );
endinterface

interface rsnc_rsp_if import rsnc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] acc_x_out;
   logic signed [SAMPLE_W-1:0] acc_y_out;
   logic signed [SAMPLE_W-1:0] acc_z_out;
   logic signed [SAMPLE_W-1:0] gyro_x_out;
   logic signed [SAMPLE_W-1:0] gyro_y_out;
   logic signed [SAMPLE_W-1:0] gyro_z_out;

   modport source (
      output valid, acc_x_out, acc_y_out, acc_z_out, gyro_x_out, gyro_y_out, gyro_z_out,
      input  ready
   );
   modport sink (
      input  valid, acc_x_out, acc_y_out, acc_z_out, gyro_x_out, gyro_y_out, gyro_z_out,
      output ready
   );
endinterface

interface rsnc_csr_if import rsnc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[sv/revolution_synchronous_noise_canceller.sv]
// A sample takes a phase/bin step, then per axis read, mean, template, update and a smoothing (acc)
// or dead-zone (gyro) step. Axes share one template RAM port and one multiplier. A new sample waits
// until the last is loaded, but a waiting result does not block acceptance; only the final load
// waits for the output register. Reset (synchronous) restores register defaults, zeroes the phase
// and seeded flag, then sweeps the template RAM to zero, one entry a cycle, before taking samples.
module revolution_synchronous_noise_canceller import rsnc_pkg::*; #(
   parameter int BINS = RSNC_BINS
) (
   input  logic          clock,
   input  logic          reset,
   rsnc_req_if.sink      req_bus,
   rsnc_rsp_if.source    rsp_bus,
   rsnc_csr_if.sink      csr_bus
);

   localparam int MEM_DEPTH = BINS * RSNC_AXES;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int BIN_W     = $clog2(BINS);
   localparam int BPROD_W   = PHASE_W + $clog2(BINS + 1);

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_BIN   = 11'b000_0000_0100,
      ST_RD    = 11'b000_0000_1000,
      ST_MM    = 11'b000_0001_0000,
      ST_MT    = 11'b000_0010_0000,
      ST_UPD   = 11'b000_0100_0000,
      ST_MA    = 11'b000_1000_0000,
      ST_AU    = 11'b001_0000_0000,
      ST_GZ    = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;

   // Saturate a 34-bit sum to the signed 32-bit fixed-point range
   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [STATE_W+1:0] v);
      logic signed [STATE_W+1:0] hi;
      logic signed [STATE_W+1:0] lo;
      hi = {3'b000, {(STATE_W-1){1'b1}}};
      lo = {3'b111, {(STATE_W-1){1'b0}}};
      if (v > hi) begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end
      return v[STATE_W-1:0];
   endfunction

   // Round half up to integer counts and saturate to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [STATE_W-1:0] v);
      logic signed [STATE_W:0]          sum;
      logic signed [STATE_W-FRAC_W:0]   r;
      sum = {v[STATE_W-1], v} + (STATE_W+1)'(32768);
      r   = sum[STATE_W:FRAC_W];
      if (r > 17'sd32767) begin
         return 16'sh7fff;
      end else if (r < -17'sd32768) begin
         return 16'sh8000;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   // Configuration registers
   logic [SYNC_RATE_W-1:0]  sync_rate_ff;
   logic [PHASE_W-1:0]      phase_step_ff;
   logic [ACC_SMOOTH_W-1:0] acc_smoothing_ff;
   logic [DEAD_ZONE_W-1:0]  gyro_dead_zone_ff;

   // Control state
   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff;
   logic [RSNC_AX_W-1:0]   ax_ff;
   logic                   seeded_ff;
   logic [PHASE_W-1:0]     phase_ff;
   logic [ADDR_W-1:0]      base_ff;
   logic                   rsp_valid_ff;

   // Datapath registers
   logic signed [SAMPLE_W-1:0] z_ff [RSNC_AXES];
   logic signed [STATE_W-1:0]  mean_ff [RSNC_AXES];
   logic signed [STATE_W-1:0]  acc_s_ff [RSNC_ACC_AXES];
   logic signed [STATE_W-1:0]  t_ff, m_ff, mn_ff, s_ff, clean_ff, prod_ff;
   logic signed [SAMPLE_W-1:0] out_ff [RSNC_AXES];
   logic signed [SAMPLE_W-1:0] rsp_ff [RSNC_AXES];

   // Template RAM
   logic [STATE_W-1:0] tmpl_mem [MEM_DEPTH];
   logic [STATE_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [STATE_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  addr;

   // Combinational helpers
   logic                       req_fire;
   logic                       rsp_free;
   logic                       last_ax;
   logic signed [STATE_W-1:0]  z32;
   logic signed [STATE_W-1:0]  m_sel, t_sel, s_sel, t_new, mean_new, s_new;
   logic signed [STATE_W:0]    mul_a;
   logic [SYNC_RATE_W-1:0]     mul_w;
   logic signed [STATE_W+SYNC_RATE_W+1:0] mul_p;
   logic signed [STATE_W+1:0]  clean_sum;
   logic [STATE_W:0]           gz_mag;
   logic [STATE_W:0]           gz_lim;
   logic [BPROD_W-1:0]         bin_prod;
   logic [BIN_W-1:0]           bin;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign last_ax  = (ax_ff == RSNC_AX_W'(RSNC_AXES - 1));
   assign z32      = {z_ff[ax_ff], {FRAC_W{1'b0}}};
   assign addr     = base_ff + ADDR_W'(ax_ff);

   // Before the first sample the selected template and the means take the sample itself
   assign t_sel = seeded_ff ? $signed(mem_rdata_ff) : z32;
   assign m_sel = seeded_ff ? mean_ff[ax_ff] : z32;
   assign s_sel = seeded_ff ? acc_s_ff[ax_ff[1:0]] : clean_ff;

   assign mean_new = m_ff + prod_ff;
   assign t_new    = t_ff + prod_ff;
   assign s_new    = s_ff + prod_ff;

   // Shared multiplier: difference times weight, floor-shifted by 16 into prod_ff
   always_comb begin
      mul_a = '0;
      mul_w = sync_rate_ff;
      case (state_ff)
         ST_MM: mul_a = {z32[STATE_W-1], z32} - {m_sel[STATE_W-1], m_sel};
         ST_MT: mul_a = {z32[STATE_W-1], z32} - {t_ff[STATE_W-1], t_ff};
         ST_MA: begin
            mul_a = {clean_ff[STATE_W-1], clean_ff} - {s_sel[STATE_W-1], s_sel};
            mul_w = acc_smoothing_ff;
         end
         default: mul_a = '0;
      endcase
   end
   assign mul_p = mul_a * $signed({1'b0, mul_w});

   // Cleaned value: sample minus updated template plus updated mean
   assign clean_sum = {{2{z32[STATE_W-1]}}, z32} - {{2{t_new[STATE_W-1]}}, t_new}
                    + {{2{mn_ff[STATE_W-1]}}, mn_ff};

   // Gyro dead zone on the unrounded value
   assign gz_mag = clean_ff[STATE_W-1] ? (STATE_W+1)'(0) - {1'b1, clean_ff}
                                       : {1'b0, clean_ff};
   assign gz_lim = {2'b00, gyro_dead_zone_ff, {FRAC_W{1'b0}}};

   // Bin from phase
   assign bin_prod = BPROD_W'(phase_ff) * BPROD_W'(BINS);
   assign bin      = BIN_W'(bin_prod[BPROD_W-1:PHASE_W]);

   // Template RAM port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr;
      mem_wdata = t_new;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_UPD) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tmpl_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= tmpl_mem[addr];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = ST_BIN;
         ST_BIN:   state_in = ST_RD;
         ST_RD:    state_in = ST_MM;
         ST_MM:    state_in = ST_MT;
         ST_MT:    state_in = ST_UPD;
         ST_UPD:   state_in = (ax_ff < RSNC_AX_W'(RSNC_ACC_AXES)) ? ST_MA : ST_GZ;
         ST_MA:    state_in = ST_AU;
         ST_AU:    state_in = ST_RD;
         ST_GZ:    state_in = last_ax ? ST_DONE : ST_RD;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ax_ff        <= '0;
         seeded_ff    <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (req_fire) begin
            phase_ff <= req_bus.new_revolution ? '0 : phase_ff + phase_step_ff;
            ax_ff    <= '0;
         end
         if (state_ff == ST_AU || (state_ff == ST_GZ && !last_ax)) begin
            ax_ff <= ax_ff + RSNC_AX_W'(1);
         end
         // A new result load takes priority over the outgoing transaction
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            seeded_ff    <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         z_ff[0] <= req_bus.acc_x_in;
         z_ff[1] <= req_bus.acc_y_in;
         z_ff[2] <= req_bus.acc_z_in;
         z_ff[3] <= req_bus.gyro_x_in;
         z_ff[4] <= req_bus.gyro_y_in;
         z_ff[5] <= req_bus.gyro_z_in;
      end
      if (state_ff == ST_BIN) begin
         base_ff <= ADDR_W'(bin) * ADDR_W'(RSNC_AXES);
      end
      if (state_ff == ST_MM || state_ff == ST_MT || state_ff == ST_MA) begin
         prod_ff <= mul_p[STATE_W+FRAC_W-1:FRAC_W];
      end
      if (state_ff == ST_MM) begin
         t_ff <= t_sel;
         m_ff <= m_sel;
      end
      if (state_ff == ST_MT) begin
         mn_ff          <= mean_new;
         mean_ff[ax_ff] <= mean_new;
      end
      if (state_ff == ST_UPD) begin
         clean_ff <= sat32(clean_sum);
      end
      if (state_ff == ST_MA) begin
         s_ff <= s_sel;
      end
      if (state_ff == ST_AU) begin
         acc_s_ff[ax_ff[1:0]] <= s_new;
         out_ff[ax_ff]        <= to_out(s_new);
      end
      if (state_ff == ST_GZ) begin
         out_ff[ax_ff] <= (gz_mag < gz_lim) ? '0 : to_out(clean_ff);
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ff <= out_ff;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_rate_ff      <= SYNC_RATE_RST;
         phase_step_ff     <= PHASE_STEP_RST;
         acc_smoothing_ff  <= ACC_SMOOTH_RST;
         gyro_dead_zone_ff <= DEAD_ZONE_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_SYNC_RATE:      sync_rate_ff      <= csr_bus.wdata[SYNC_RATE_W-1:0];
            CSR_PHASE_STEP:     phase_step_ff     <= csr_bus.wdata[PHASE_W-1:0];
            CSR_ACC_SMOOTHING:  acc_smoothing_ff  <= csr_bus.wdata[ACC_SMOOTH_W-1:0];
            CSR_GYRO_DEAD_ZONE: gyro_dead_zone_ff <= csr_bus.wdata[DEAD_ZONE_W-1:0];
            default:            sync_rate_ff      <= sync_rate_ff;
         endcase
      end
   end

   // Port drive
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.acc_x_out  = rsp_ff[0];
   assign rsp_bus.acc_y_out  = rsp_ff[1];
   assign rsp_bus.acc_z_out  = rsp_ff[2];
   assign rsp_bus.gyro_x_out = rsp_ff[3];
   assign rsp_bus.gyro_y_out = rsp_ff[4];
   assign rsp_bus.gyro_z_out = rsp_ff[5];

   // Axis counter never leaves the six axes
   a_ax_range: assert property (@(posedge clock) disable iff (reset)
      ax_ff < RSNC_AX_W'(RSNC_AXES))
      else $error("axis counter out of range");

   // Template RAM is only written by the clearing sweep or a template update
   a_mem_we_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !mem_we)
      else $error("template RAM written outside update");

   // No result appears while the RAM is still being cleared
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result valid during clearing sweep");

   // Delivering a result leaves the state seeded
   a_seed_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (seeded_ff && rsp_valid_ff))
      else $error("result load did not seed state");

endmodule

[tb/sv/revolution_synchronous_noise_canceller_tb.sv]
// Self-checking testbench for the revolution-synchronous noise canceller.
module revolution_synchronous_noise_canceller_tb import rsnc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Six axes packed low to high: acc x, y, z then gyro x, y, z
   typedef logic [RSNC_AXES-1:0][SAMPLE_W-1:0] axis_vec_type;

   typedef struct packed {
      logic         new_revolution;
      axis_vec_type axis;
   } imu_sample_type;

   // Predicts cleaned outputs and checks them in order
   class canceller_scoreboard;
      bit [SYNC_RATE_W-1:0]  sync_rate;
      bit [PHASE_W-1:0]      phase_step;
      bit [ACC_SMOOTH_W-1:0] acc_smoothing;
      bit [DEAD_ZONE_W-1:0]  gyro_dead_zone;
      bit [PHASE_W-1:0]      phase;
      int                    templates[RSNC_BINS*RSNC_AXES];
      int                    means[RSNC_AXES];
      int                    acc_smoothed[RSNC_ACC_AXES];
      bit                    seeded;
      bit                    acc_seeded;
      axis_vec_type          expected_cleaned[$];
      int                    failures;
      string                 names[RSNC_AXES];

      function new();
         sync_rate      = SYNC_RATE_RST;
         phase_step     = PHASE_STEP_RST;
         acc_smoothing  = ACC_SMOOTH_RST;
         gyro_dead_zone = DEAD_ZONE_RST;
         phase          = '0;
         seeded         = 1'b0;
         acc_seeded     = 1'b0;
         failures       = 0;
         foreach (templates[i]) templates[i] = 0;
         foreach (means[i]) means[i] = 0;
         foreach (acc_smoothed[i]) acc_smoothed[i] = 0;
         names = '{"acc_x_out", "acc_y_out", "acc_z_out",
                   "gyro_x_out", "gyro_y_out", "gyro_z_out"};
      endfunction

      // Bits above each register's width are dropped
      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SYNC_RATE:      sync_rate      = data[SYNC_RATE_W-1:0];
            CSR_PHASE_STEP:     phase_step     = data[PHASE_W-1:0];
            CSR_ACC_SMOOTHING:  acc_smoothing  = data[ACC_SMOOTH_W-1:0];
            CSR_GYRO_DEAD_ZONE: gyro_dead_zone = data[DEAD_ZONE_W-1:0];
            default: ;
         endcase
      endfunction

      // Exponential average, shift rounds towards minus infinity
      function int average(int s, longint x, bit [15:0] w);
         longint d;
         longint wl;
         wl = w;
         d  = x - longint'(s);
         return int'(longint'(s) + ((d * wl) >>> FRAC_W));
      endfunction

      // Q16.16 to sensor counts, round half up, saturate
      function logic [SAMPLE_W-1:0] round_out(longint v);
         longint r;
         r = (v + 32768) >>> FRAC_W;
         if (r > 32767) r = 32767;
         else if (r < -32768) r = -32768;
         return r[SAMPLE_W-1:0];
      endfunction

      function void note_sample(imu_sample_type s);
         longint       z[RSNC_AXES];
         longint       clean[RSNC_AXES];
         longint       v;
         longint       mag;
         int           bin;
         int           k;
         axis_vec_type res;

         foreach (z[i]) z[i] = longint'($signed(s.axis[i])) * 65536;

         // Phase restarts on a new revolution, else advances and wraps
         if (s.new_revolution) phase = '0;
         else phase = phase + phase_step;
         bin = int'((longint'(phase) * RSNC_BINS) >>> PHASE_W);
         if (bin >= RSNC_BINS) bin = RSNC_BINS - 1;

         // First sample seeds the selected bin and the means
         if (!seeded) begin
            for (int i = 0; i < RSNC_AXES; i++) begin
               templates[bin*RSNC_AXES+i] = int'(z[i]);
               means[i] = int'(z[i]);
            end
            seeded = 1'b1;
         end

         for (int i = 0; i < RSNC_AXES; i++) begin
            k = bin*RSNC_AXES + i;
            means[i]     = average(means[i], z[i], sync_rate);
            templates[k] = average(templates[k], z[i], sync_rate);
            clean[i] = z[i] - longint'(templates[k]) + longint'(means[i]);
            if (clean[i] > 64'sd2147483647) clean[i] = 64'sd2147483647;
            else if (clean[i] < -64'sd2147483648) clean[i] = -64'sd2147483648;
         end

         // Accelerometer smoothing, seeded by its first value
         if (!acc_seeded) begin
            for (int i = 0; i < RSNC_ACC_AXES; i++) acc_smoothed[i] = int'(clean[i]);
            acc_seeded = 1'b1;
         end
         for (int i = 0; i < RSNC_ACC_AXES; i++) begin
            acc_smoothed[i] = average(acc_smoothed[i], clean[i], acc_smoothing);
            res[i] = round_out(acc_smoothed[i]);
         end

         // Gyro dead zone on the unrounded value
         for (int i = RSNC_ACC_AXES; i < RSNC_AXES; i++) begin
            v   = clean[i];
            mag = (v < 0) ? -v : v;
            if (mag < longint'(gyro_dead_zone) * 65536) v = 0;
            res[i] = round_out(v);
         end
         expected_cleaned.push_back(res);
      endfunction

      function void check_result(axis_vec_type got);
         axis_vec_type want;
         if (expected_cleaned.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result transaction with nothing pending", $time);
            return;
         end
         want = expected_cleaned.pop_front();
         for (int i = 0; i < RSNC_AXES; i++) begin
            if (got[i] !== want[i]) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: %s mismatch, expected %0d, got %0d", $time, names[i],
                           $signed(want[i]), $signed(got[i]));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsnc_req_if req_bus ();
   rsnc_rsp_if rsp_bus ();
   rsnc_csr_if csr_bus ();

   revolution_synchronous_noise_canceller uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   canceller_scoreboard board = new();

   // Idle and stall rates in percent, and the revolution-shaped stimulus profile
   int idle_pct  = 0;
   int stall_pct = 0;
   bit quiet     = 1'b0;
   int rev_len   = 50;
   int rev_pos   = 0;
   int offsets[RSNC_AXES];
   int amps[RSNC_AXES];
   int noise     = 0;

   always #6 clock = ~clock;

   // Result side: ready held low in random bursts
   initial begin : result_sink
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready = 1'b0;
         end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            hold = $urandom_range(15);
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Every result transaction goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result({rsp_bus.gyro_z_out, rsp_bus.gyro_y_out, rsp_bus.gyro_x_out,
                             rsp_bus.acc_z_out, rsp_bus.acc_y_out, rsp_bus.acc_x_out});
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic send_sample(imu_sample_type s);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat ($urandom_range(15)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid          = 1'b1;
      req_bus.new_revolution = s.new_revolution;
      {req_bus.gyro_z_in, req_bus.gyro_y_in, req_bus.gyro_x_in,
       req_bus.acc_z_in, req_bus.acc_y_in, req_bus.acc_x_in} = s.axis;
      do @(posedge clock); while (!req_bus.ready);
      board.note_sample(s);
   endtask

   task automatic push_directed(bit nr, int ax, int ay, int az, int gx, int gy, int gz);
      imu_sample_type s;
      s.new_revolution = nr;
      s.axis = {gz[15:0], gy[15:0], gx[15:0], az[15:0], ay[15:0], ax[15:0]};
      send_sample(s);
   endtask

   // Hold the input side idle until every expected result has come back
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.expected_cleaned.size() != 0) @(posedge clock);
   endtask

   // Register write, with random junk above the register's width
   task automatic write_register(csr_index_type idx, int unsigned value, int w);
      int unsigned           mask;
      logic [CSR_DATA_W-1:0] data;
      mask = (32'd1 << w) - 1;
      data = CSR_DATA_W'(($urandom & ~mask) | (value & mask));
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_register(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure(int unsigned rate, int unsigned step, int unsigned smooth,
                            int unsigned dead_zone);
      drain_results();
      write_register(CSR_SYNC_RATE, rate, SYNC_RATE_W);
      write_register(CSR_PHASE_STEP, step, PHASE_W);
      write_register(CSR_ACC_SMOOTHING, smooth, ACC_SMOOTH_W);
      write_register(CSR_GYRO_DEAD_ZONE, dead_zone, DEAD_ZONE_W);
   endtask

   task automatic set_profile(int span, int amp_max, int noise_max);
      for (int i = 0; i < RSNC_AXES; i++) begin
         offsets[i] = int'($urandom_range(2*span)) - span;
         amps[i]    = $urandom_range(amp_max);
      end
      noise = noise_max;
   endtask

   // Mostly revolution-periodic samples; some stray or missing markers and raw noise
   task automatic run_random(int count);
      imu_sample_type s;
      int             v;
      int             kind;
      int             tri_pos;
      int             wave;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            if (quiet) begin
               idle_pct  = 0;
               stall_pct = 0;
            end else begin
               idle_pct  = 30 * $urandom_range(2);
               stall_pct = 30 * $urandom_range(2);
            end
         end
         if ($urandom_range(199) == 0) rev_len = $urandom_range(4, 120);
         kind = $urandom_range(99);
         rev_pos++;
         s.new_revolution = 1'b0;
         if (rev_pos >= rev_len) begin
            rev_pos = 0;
            s.new_revolution = (kind < 85);
         end
         if (kind >= 80 && kind < 90 && $urandom_range(1) == 1) begin
            s.new_revolution = 1'b1;
            rev_pos = 0;
         end
         if (kind >= 90) begin
            s.axis = {$urandom, $urandom, $urandom};
            s.new_revolution = 1'($urandom_range(1));
         end else begin
            tri_pos = rev_pos * 64 / rev_len;
            wave = ((tri_pos < 32) ? tri_pos : 63 - tri_pos) - 16;
            for (int i = 0; i < RSNC_AXES; i++) begin
               v = offsets[i] + amps[i] * wave / 16 + int'($urandom_range(2*noise)) - noise;
               if (v > 32767) v = 32767;
               else if (v < -32768) v = -32768;
               s.axis[i] = v[15:0];
            end
         end
         send_sample(s);
      end
   endtask

   initial begin : stimulus
      req_bus.valid          = 1'b0;
      req_bus.new_revolution = 1'b0;
      req_bus.acc_x_in       = '0;
      req_bus.acc_y_in       = '0;
      req_bus.acc_z_in       = '0;
      req_bus.gyro_x_in      = '0;
      req_bus.gyro_y_in      = '0;
      req_bus.gyro_z_in      = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = CSR_SYNC_RATE;
      csr_bus.wdata          = '0;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: seeding, field extremes, revolution markers, dead zone edges
      push_directed(1, -32768, -32768, -32768, 32767, 32767, 32767);
      push_directed(0, 32767, 32767, 32767, -32768, -32768, -32768);
      push_directed(0, 0, 0, 0, 0, 0, 0);
      push_directed(1, 0, 0, 0, 0, 0, 0);
      push_directed(0, 0, 0, 0, 0, 0, 0);
      push_directed(0, 15, -15, 16, 15, -15, 16);
      push_directed(0, -16, 16, 17, -16, 16, -17);
      push_directed(0, 21845, -21846, 21845, -21846, 21845, -21846);
      push_directed(0, -21846, 21845, -21846, 21845, -21846, 21845);
      push_directed(1, -1, 1, -1, 1, -1, 1);
      push_directed(0, 32767, -32768, 32767, -32768, 32767, -32768);
      push_directed(1, 32767, 32767, 32767, 32767, 32767, 32767);
      push_directed(1, -32768, -32768, -32768, -32768, -32768, -32768);
      push_directed(0, 100, -100, 0, 0, 0, 0);
      push_directed(0, 1, 2, 3, 4, 5, 6);

      set_profile(200, 100, 8);
      run_random(250);

      // Every register at its maximum
      configure(65535, 16777215, 65535, 32767);
      set_profile(30000, 2000, 2000);
      run_random(250);

      // Every register zero: averages hold, bin holds
      configure(0, 0, 0, 0);
      set_profile(20000, 4000, 300);
      run_random(250);

      // Fast tracking with a narrow dead zone and tiny gyro values
      configure(65535, 600000, 1, 20);
      set_profile(40, 10, 30);
      run_random(250);

      for (int p = 0; p < 3; p++) begin
         configure($urandom_range(1) ? $urandom_range(2000) : $urandom_range(65535),
                   $urandom_range(16777215), $urandom_range(65535),
                   $urandom_range(1) ? $urandom_range(64) : $urandom_range(32767));
         set_profile($urandom_range(32767), $urandom_range(8000), $urandom_range(500));
         run_random(250);
      end

      // Closing stretch at the reset settings with no idling
      configure(32'(SYNC_RATE_RST), 32'(PHASE_STEP_RST), 32'(ACC_SMOOTH_RST),
                32'(DEAD_ZONE_RST));
      quiet = 1'b1;
      set_profile(1000, 300, 20);
      run_random(250);

      drain_results();
      repeat (64) @(posedge clock);
      if (board.failures == 0 && board.expected_cleaned.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
